// ----- hw/rtl/ctb_pkg.sv -----
// Shared types and constants for the countdown timer bank.
// Used by ctb_mem, ctb_seq, the top level and the port checker; depends on nothing.
package ctb_pkg;

	// Request codes carried on req_type. Codes above REQ_QUERY are ignored.
	localparam logic [2:0] REQ_TICK   = 3'd0;
	localparam logic [2:0] REQ_SET    = 3'd1;
	localparam logic [2:0] REQ_CANCEL = 3'd2;
	localparam logic [2:0] REQ_FIRE   = 3'd3;
	localparam logic [2:0] REQ_QUERY  = 3'd4;

	// Kinds of result.
	localparam logic KIND_EXPIRY = 1'b0;
	localparam logic KIND_REPLY  = 1'b1;

	// Configuration register map and reset value.
	localparam logic [2:0]  ADDR_TICK_STEP  = 3'd0;
	localparam logic [15:0] TICK_STEP_RESET = 16'd100;

	// One stored timer: active mark and remaining milliseconds.
	typedef struct packed {
		logic        active;
		logic [31:0] rem_ms;
	} entry_t;

	// One result transaction as it leaves the sequencer.
	typedef struct packed {
		logic        kind;
		logic [3:0]  index;
		logic [31:0] rem_ms;
		logic        was_active;
		logic        fired;
		logic        last;
	} result_t;

endpackage

// ----- hw/rtl/countdown_timer_bank_top.sv -----
// Top level of the countdown timer bank: APB register, sequencer and state memory.
// Depends on ctb_pkg, ctb_mem and ctb_seq.
//
// Usage: a request transaction is taken at a clock edge where start is high and
// busy is low. Set, cancel, fire-now and query each give one reply; the result
// strobe is registered from the ST_REQ state and lasts one cycle. Busy stays high
// through that state, so the next request waits until the reply is built.
// A tick sweeps the timer memory one entry per cycle through its single read
// port; busy stays high through the sweep and the ST_FLUSH state after it, so
// the next request waits for both. Expiry results come in ascending index
// order, each a one-cycle strobe; the last one carries last_result. A tick that
// expires nothing gives no result.
// Results cannot be held off: each is valid for exactly its strobe cycle.
// Request codes 5 to 7 are taken and ignored without raising busy.
// tick_step is written over APB at byte address 0 and should change only while
// idle. Reset clears every timer to zero and inactive, sets tick_step to 100.
module countdown_timer_bank_top #(
	parameter int NUM_TIMERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [3:0]  timer_index,
	input  logic [31:0] timeout_value,
	output logic        result_strobe,
	output logic        result_kind,
	output logic [3:0]  result_index,
	output logic [31:0] remaining_time,
	output logic        was_active,
	output logic        fired,
	output logic        last_result
);
	import ctb_pkg::*;

	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	logic [15:0] tick_step_q;
	logic        rd_en;
	logic        wr_en;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	entry_t      rd_data;
	entry_t      wr_data;
	logic        res_vld;
	result_t     res;

	// Configuration register: written in the APB access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_step_q <= TICK_STEP_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_TICK_STEP[2])) begin
			tick_step_q <= pwdata[15:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == ADDR_TICK_STEP[2]) ? {16'd0, tick_step_q} : '0;

	ctb_seq #(
		.NUM_TIMERS (NUM_TIMERS),
		.AW         (AW)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.req_type      (req_type),
		.timer_index   (timer_index),
		.timeout_value (timeout_value),
		.tick_step     (tick_step_q),
		.busy          (busy),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.res_vld       (res_vld),
		.res           (res)
	);

	ctb_mem #(
		.DEPTH (NUM_TIMERS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Result ports.
	assign result_strobe  = res_vld;
	assign result_kind    = res.kind;
	assign result_index   = res.index;
	assign remaining_time = res.rem_ms;
	assign was_active     = res.was_active;
	assign fired          = res.fired;
	assign last_result    = res.last;

endmodule

// ----- hw/rtl/ctb_mem.sv -----
// Timer state memory: one synchronous read port and one write port, registered read data.
// Per-entry valid flops make never-written entries read as zero. Depends on ctb_pkg.
module ctb_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output ctb_pkg::entry_t  rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  ctb_pkg::entry_t  wr_data
);
	import ctb_pkg::*;

	entry_t           mem_q [DEPTH];
	entry_t           rd_q;
	logic [DEPTH-1:0] vld_q;
	logic             rd_vld_q;

	// Storage array with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// Valid bits are cleared by reset and set by the first write of an entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// An entry that was never written reads as its reset value, zero.
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// ----- hw/rtl/ctb_seq.sv -----
// Request sequencer: decodes requests, sweeps the memory on a tick and builds results.
// Drives the read and write ports of ctb_mem. Depends on ctb_pkg.
module ctb_seq #(
	parameter int NUM_TIMERS = 16,
	parameter int AW         = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2:0]        req_type,
	input  logic [3:0]        timer_index,
	input  logic [31:0]       timeout_value,
	input  logic [15:0]       tick_step,
	output logic              busy,
	output logic              rd_en,
	output logic [AW-1:0]     rd_addr,
	input  ctb_pkg::entry_t   rd_data,
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output ctb_pkg::entry_t   wr_data,
	output logic              res_vld,
	output ctb_pkg::result_t  res
);
	import ctb_pkg::*;

	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TIMERS - 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_REQ   = 4'b0010,
		ST_TICK  = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	state_t        state_q, nxt_state;
	logic [AW-1:0] cur_q;
	logic          pend_vld_q;
	logic [AW-1:0] pend_idx_q;
	logic [2:0]    req_q;
	logic [3:0]    idx_q;
	logic [31:0]   val_q;
	logic          in_range_q;
	logic          res_vld_q;
	result_t       res_q;
	logic          res_vld_d;
	result_t       res_d;
	logic          expire;
	logic          accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);

	// Next state, memory access and result for the current cycle.
	always_comb begin
		nxt_state = state_q;
		rd_en     = 1'b0;
		rd_addr   = cur_q + AW'(1);
		wr_en     = 1'b0;
		wr_addr   = cur_q;
		wr_data   = rd_data;
		expire    = 1'b0;
		res_vld_d = 1'b0;
		res_d     = '0;
		case (state_q)
			ST_IDLE: begin
				// Read the addressed entry in the same cycle as the transaction is taken.
				rd_en   = start;
				rd_addr = (req_type == REQ_TICK) ? '0 : AW'(timer_index);
				if (start) begin
					if (req_type == REQ_TICK) begin
						nxt_state = ST_TICK;
					end else if (req_type <= REQ_QUERY) begin
						nxt_state = ST_REQ;
					end
				end
			end
			ST_REQ: begin
				// Single-timer request: modify the entry just read and reply.
				res_vld_d   = 1'b1;
				res_d.kind  = KIND_REPLY;
				res_d.index = idx_q;
				res_d.last  = 1'b1;
				wr_addr     = AW'(idx_q);
				if (in_range_q) begin
					res_d.rem_ms = rd_data.rem_ms;
					case (req_q)
						REQ_SET: begin
							wr_en        = 1'b1;
							wr_data      = '{active: 1'b1, rem_ms: val_q};
							res_d.rem_ms = val_q;
						end
						REQ_CANCEL: begin
							wr_en            = 1'b1;
							wr_data.active   = 1'b0;
							res_d.was_active = rd_data.active;
						end
						REQ_FIRE: begin
							wr_en            = 1'b1;
							wr_data.active   = 1'b0;
							res_d.was_active = rd_data.active;
							res_d.fired      = rd_data.active;
						end
						default: begin
						end
					endcase
				end
				nxt_state = ST_IDLE;
			end
			ST_TICK: begin
				// Sweep: update entry cur_q while the next one is read.
				rd_en = (cur_q != LAST_IDX);
				if (rd_data.active) begin
					wr_en = 1'b1;
					if (rd_data.rem_ms > {16'd0, tick_step}) begin
						wr_data.rem_ms = rd_data.rem_ms - {16'd0, tick_step};
					end else begin
						wr_data = '0;
						expire  = 1'b1;
					end
				end
				// An expiry is held back one find so the final one can be marked last.
				if (expire && pend_vld_q) begin
					res_vld_d        = 1'b1;
					res_d.kind       = KIND_EXPIRY;
					res_d.index      = 4'(pend_idx_q);
					res_d.was_active = 1'b1;
					res_d.fired      = 1'b1;
				end
				if (cur_q == LAST_IDX) begin
					nxt_state = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				// Deliver the held expiry as the final result of the tick.
				if (pend_vld_q) begin
					res_vld_d        = 1'b1;
					res_d.kind       = KIND_EXPIRY;
					res_d.index      = 4'(pend_idx_q);
					res_d.was_active = 1'b1;
					res_d.fired      = 1'b1;
					res_d.last       = 1'b1;
				end
				nxt_state = ST_IDLE;
			end
			default: begin
				nxt_state = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cur_q      <= '0;
			pend_vld_q <= 1'b0;
			pend_idx_q <= '0;
			res_vld_q  <= 1'b0;
		end else begin
			state_q   <= nxt_state;
			res_vld_q <= res_vld_d;
			if (accept) begin
				cur_q      <= '0;
				pend_vld_q <= 1'b0;
			end else if (state_q == ST_TICK) begin
				cur_q <= cur_q + AW'(1);
				if (expire) begin
					pend_vld_q <= 1'b1;
					pend_idx_q <= cur_q;
				end
			end
		end
	end

	// Captured request and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q      <= req_type;
			idx_q      <= timer_index;
			val_q      <= timeout_value;
			in_range_q <= (32'(timer_index) < NUM_TIMERS);
		end
		res_q <= res_d;
	end

	assign res_vld = res_vld_q;
	assign res     = res_q;

endmodule

// ----- hw/rtl/ctb_chk.sv -----
// Port-level checker for the countdown timer bank and its bind to the top level.
// Depends on ctb_pkg and countdown_timer_bank_top.
module ctb_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [2:0]  req_type,
	input logic [3:0]  timer_index,
	input logic        result_strobe,
	input logic        result_kind,
	input logic [3:0]  result_index,
	input logic [31:0] remaining_time,
	input logic        was_active,
	input logic        fired,
	input logic        last_result
);
	import ctb_pkg::*;

	logic req_single;

	assign req_single = start && !busy &&
		(req_type == REQ_SET || req_type == REQ_CANCEL ||
		 req_type == REQ_FIRE || req_type == REQ_QUERY);

	// A result only follows a cycle in which the block was working.
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result strobe without preceding busy cycle");

	// A single-timer request is answered by one final reply that carries its index.
	a_reply_timing: assert property (@(posedge clk) disable iff (!arst_n)
		req_single |-> ##2 (result_strobe && result_kind == KIND_REPLY && last_result
			&& result_index == $past(timer_index, 2)))
		else $error("reply missing or wrong for single-timer request");

	// Expiry reports always carry a fired, previously active timer at zero.
	a_expiry_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result_kind == KIND_EXPIRY) |->
			(fired && was_active && remaining_time == 32'd0))
		else $error("expiry report with inconsistent fields");

	// Ticks and valid requests occupy the block after they are taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req_type == REQ_TICK || req_single)) |=> busy)
		else $error("block not busy after accepting a request");

endmodule

bind countdown_timer_bank_top ctb_chk u_ctb_chk (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for countdown_timer_bank_top: directed table, then random requests.
// Predicts replies and expiry reports from its own timer bank model; depends on ctb_pkg.
// Also writes and reads back tick_step over APB between request phases.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ctb_pkg::*;

	localparam int N_TIMERS = 16;
	localparam int CYCLE_LIMIT = 300000;
	localparam int ITEMS_PER_PHASE = 36;
	localparam int N_PHASES = 6;
	localparam int DIR_ROWS = 26;
	localparam int MAX_REPORTS = 10;

	// Request codes outside the defined set; the block must ignore them.
	localparam logic [2:0] REQ_RSVD5 = 3'd5;
	localparam logic [2:0] REQ_RSVD6 = 3'd6;
	localparam logic [2:0] REQ_RSVD7 = 3'd7;

	// One row of the directed table. When pin is set, the reply is typed in here.
	typedef struct packed {
		logic [2:0]  req;
		logic [3:0]  idx;
		logic [31:0] val;
		bit          pin;
		logic [31:0] rem;
		bit          was;
		bit          fired;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	logic [2:0]  req_type;
	logic [3:0]  timer_index;
	logic [31:0] timeout_value;
	logic        result_strobe;
	logic        result_kind;
	logic [3:0]  result_index;
	logic [31:0] remaining_time;
	logic        was_active;
	logic        fired;
	logic        last_result;

	// Shadow of the timer bank and of the tick_step register.
	logic [31:0] timer_rem [N_TIMERS];
	bit          timer_armed [N_TIMERS];
	logic [15:0] cur_step;

	// Results still owed by the block, oldest first.
	result_t     owed_results [$];

	// Typed-in reply for the request currently on the ports.
	bit          pin_valid;
	result_t     pin_result;

	bit          idle_on;
	int          mismatches;
	int          cycle_count;

	dir_row_t dir_table [DIR_ROWS] = '{
		'{REQ_QUERY,  4'd0,  32'd0,         1'b1, 32'd0,         1'b0, 1'b0},
		'{REQ_QUERY,  4'd15, 32'hFFFF_FFFF, 1'b1, 32'd0,         1'b0, 1'b0},
		'{REQ_TICK,   4'd0,  32'd0,         1'b0, 32'd0,         1'b0, 1'b0},
		'{REQ_CANCEL, 4'd3,  32'd0,         1'b1, 32'd0,         1'b0, 1'b0},
		'{REQ_FIRE,   4'd3,  32'd0,         1'b1, 32'd0,         1'b0, 1'b0},
		'{REQ_SET,    4'd0,  32'd0,         1'b1, 32'd0,         1'b0, 1'b0},
		'{REQ_SET,    4'd15, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0},
		'{REQ_SET,    4'd1,  32'd100,       1'b1, 32'd100,       1'b0, 1'b0},
		'{REQ_SET,    4'd2,  32'd101,       1'b1, 32'd101,       1'b0, 1'b0},
		'{REQ_SET,    4'd5,  32'd250,       1'b1, 32'd250,       1'b0, 1'b0},
		'{REQ_TICK,   4'd0,  32'd0,         1'b0, 32'd0,         1'b0, 1'b0},
		'{REQ_QUERY,  4'd2,  32'd0,         1'b0, 32'd0,         1'b0, 1'b0},
		'{REQ_QUERY,  4'd15, 32'd0,         1'b0, 32'd0,         1'b0, 1'b0},
		'{REQ_CANCEL, 4'd5,  32'd0,         1'b1, 32'd150,       1'b1, 1'b0},
		'{REQ_CANCEL, 4'd5,  32'd0,         1'b1, 32'd150,       1'b0, 1'b0},
		'{REQ_SET,    4'd7,  32'd12345,     1'b1, 32'd12345,     1'b0, 1'b0},
		'{REQ_FIRE,   4'd7,  32'd0,         1'b1, 32'd12345,     1'b1, 1'b1},
		'{REQ_FIRE,   4'd7,  32'd0,         1'b1, 32'd12345,     1'b0, 1'b0},
		'{REQ_RSVD5,  4'd8,  32'd1,         1'b0, 32'd0,         1'b0, 1'b0},
		'{REQ_RSVD6,  4'd12, 32'hFFFF_FFFF, 1'b0, 32'd0,         1'b0, 1'b0},
		'{REQ_RSVD7,  4'd15, 32'd0,         1'b0, 32'd0,         1'b0, 1'b0},
		'{REQ_TICK,   4'd0,  32'd0,         1'b0, 32'd0,         1'b0, 1'b0},
		'{REQ_SET,    4'd10, 32'h5555_5555, 1'b1, 32'h5555_5555, 1'b0, 1'b0},
		'{REQ_SET,    4'd9,  32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA, 1'b0, 1'b0},
		'{REQ_QUERY,  4'd10, 32'd0,         1'b1, 32'h5555_5555, 1'b0, 1'b0},
		'{REQ_TICK,   4'd0,  32'd0,         1'b0, 32'd0,         1'b0, 1'b0}
	};

	countdown_timer_bank_top #(
		.NUM_TIMERS(N_TIMERS)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.timer_index   (timer_index),
		.timeout_value (timeout_value),
		.result_strobe (result_strobe),
		.result_kind   (result_kind),
		.result_index  (result_index),
		.remaining_time(remaining_time),
		.was_active    (was_active),
		.fired         (fired),
		.last_result   (last_result)
	);

	always #5 clk = ~clk;

	function automatic string show(result_t r);
		return $sformatf("kind=%0d idx=%0d rem=%h was=%0d fired=%0d last=%0d",
			r.kind, r.index, r.rem_ms, r.was_active, r.fired, r.last);
	endfunction

	function automatic void log_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t: %s", $realtime, msg);
		end
	endfunction

	// Apply one accepted request to the shadow bank and queue what it must produce.
	function automatic void predict_request(logic [2:0] req, logic [3:0] idx,
			logic [31:0] val);
		int i;
		int last_hit;
		bit was;
		bit hit;
		if (req == REQ_TICK) begin
			// Find the highest expiring timer first, it carries last_result.
			last_hit = -1;
			for (i = 0; i < N_TIMERS; i++) begin
				if (timer_armed[i] && timer_rem[i] <= {16'd0, cur_step}) begin
					last_hit = i;
				end
			end
			for (i = 0; i < N_TIMERS; i++) begin
				if (timer_armed[i]) begin
					if (timer_rem[i] > {16'd0, cur_step}) begin
						timer_rem[i] = timer_rem[i] - {16'd0, cur_step};
					end else begin
						timer_rem[i] = 32'd0;
						timer_armed[i] = 1'b0;
						owed_results.push_back('{KIND_EXPIRY, 4'(i), 32'd0, 1'b1, 1'b1,
							i == last_hit});
					end
				end
			end
		end else if (req <= REQ_QUERY) begin
			was = 1'b0;
			hit = 1'b0;
			case (req)
				REQ_SET: begin
					timer_rem[idx] = val;
					timer_armed[idx] = 1'b1;
				end
				REQ_CANCEL: begin
					was = timer_armed[idx];
					timer_armed[idx] = 1'b0;
				end
				REQ_FIRE: begin
					was = timer_armed[idx];
					hit = was;
					timer_armed[idx] = 1'b0;
				end
				default: begin
				end
			endcase
			owed_results.push_back('{KIND_REPLY, idx, timer_rem[idx], was, hit, 1'b1});
		end
	endfunction

	// Result checking and request prediction, both on the rising edge.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (result_strobe) begin
				got = '{result_kind, result_index, remaining_time, was_active, fired,
					last_result};
				if (owed_results.size() == 0) begin
					log_mismatch({"result with nothing owed: ", show(got)});
				end else begin
					want = owed_results.pop_front();
					if (got !== want) begin
						log_mismatch({"mismatch: exp ", show(want), " got ", show(got)});
					end
				end
			end
			if (start && !busy) begin
				predict_request(req_type, timer_index, timeout_value);
				if (pin_valid) begin
					void'(owed_results.pop_back());
					owed_results.push_back(pin_result);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Present one request and hold it until the block takes it. Entered and left
	// just after a falling edge.
	task automatic issue_request(logic [2:0] req, logic [3:0] idx, logic [31:0] val,
			bit pin, result_t pinned);
		int gap;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		timer_index <= idx;
		timeout_value <= val;
		pin_valid <= pin;
		pin_result <= pinned;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Stop requesting, wait for every owed result, then let a silent tick finish.
	task automatic drain();
		start <= 1'b0;
		while (owed_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (N_TIMERS + 4) @(negedge clk);
	endtask

	// APB write of tick_step followed by a read back of the same register.
	task automatic write_tick_step(logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_TICK_STEP;
		pwdata <= {16'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		cur_step = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== value) begin
			log_mismatch($sformatf("tick_step read back: exp %h got %h", value,
				prdata[15:0]));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Timeout biased toward the current step so that expiries are common.
	function automatic logic [31:0] pick_timeout();
		int r;
		r = $urandom_range(0, 9);
		if (r <= 5) begin
			return $urandom_range(0, 3 * int'(cur_step) + 2);
		end else if (r == 6) begin
			return 32'd0;
		end else if (r == 7) begin
			return 32'hFFFF_FFFF;
		end else if (r == 8) begin
			return {16'd0, cur_step};
		end
		return $urandom;
	endfunction

	initial begin
		int i;
		int p;
		int counted;
		int r;
		logic [2:0] req;
		logic [15:0] step_plan [N_PHASES];
		dir_row_t row;

		// All inputs known from time zero while reset is held low.
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_TICK_STEP;
		pwdata = 32'd0;
		start = 1'b0;
		req_type = REQ_TICK;
		timer_index = 4'd0;
		timeout_value = 32'd0;
		pin_valid = 1'b0;
		pin_result = '0;
		mismatches = 0;
		cycle_count = 0;
		cur_step = TICK_STEP_RESET;
		for (i = 0; i < N_TIMERS; i++) begin
			timer_rem[i] = 32'd0;
			timer_armed[i] = 1'b0;
		end
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table.
		idle_on = 1'b1;
		for (i = 0; i < DIR_ROWS; i++) begin
			row = dir_table[i];
			issue_request(row.req, row.idx, row.val, row.pin,
				'{KIND_REPLY, row.idx, row.rem, row.was, row.fired, 1'b1});
		end

		// Random phases, each under its own tick_step; the first keeps the reset value.
		step_plan[0] = TICK_STEP_RESET;
		step_plan[1] = 16'd1;
		step_plan[2] = 16'd0;
		step_plan[3] = 16'hFFFF;
		step_plan[4] = 16'($urandom_range(1, 65535));
		step_plan[5] = 16'($urandom_range(0, 65535));
		for (p = 0; p < N_PHASES; p++) begin
			if (p > 0) begin
				drain();
				write_tick_step(step_plan[p]);
			end
			idle_on = ($urandom_range(0, 3) != 0);
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 25) begin
					req = REQ_TICK;
				end else if (r < 55) begin
					req = REQ_SET;
				end else if (r < 67) begin
					req = REQ_CANCEL;
				end else if (r < 79) begin
					req = REQ_FIRE;
				end else if (r < 94) begin
					req = REQ_QUERY;
				end else begin
					req = 3'($urandom_range(REQ_RSVD5, REQ_RSVD7));
				end
				if (req <= REQ_QUERY) begin
					counted++;
				end
				issue_request(req, 4'($urandom_range(0, N_TIMERS - 1)),
					(req == REQ_SET) ? pick_timeout() : $urandom, 1'b0, '0);
			end
		end

		drain();
		if (owed_results.size() != 0) begin
			log_mismatch($sformatf("%0d results never arrived", owed_results.size()));
		end
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
